// ----- hdl/tbdc_pkg.sv -----
// Shared constants for the triple-buffer DC tracker.
// Fixed stream widths and sum width; no dependencies.
`timescale 1ns / 1ps

package tbdc_pkg;

    // Width of the input sample field in the slave-side stream.
    localparam int IN_DATA_W  = 24;
    // Running sum carries one guard bit over the reported window sum.
    localparam int SUM_W      = 33;
    localparam int WINDOW_W   = 32;
    localparam int IDX_W      = 2;
    // window_sum and done_buffer_index, padded to whole bytes.
    localparam int OUT_DATA_W = 40;

    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [WINDOW_W-1:0] t_window;
    typedef logic [IDX_W-1:0]    t_idx;

endpackage

// ----- hdl/triple_buffer_dc_tracker_core.sv -----
// Triple-buffer DC tracker: boxcar moving sum over a ring of sample buffers.
// Depends on tbdc_pkg for stream widths and the sum type.
`timescale 1ns / 1ps

// Takes one signed sample per transaction and returns one result per
// transaction: the sum of the last BUFFER_SAMPLES samples (the DC mean is this
// sum divided by BUFFER_SAMPLES), a tlast flag on the sample that fills a
// buffer, and the index of the last finished buffer. Samples live in a single
// BUFFER_COUNT x BUFFER_SAMPLES memory with one write and one read port; the
// sample leaving the window is read in the same cycle the new one is written,
// so the block takes one sample every clock cycle unless the output stalls,
// and a result passes the stage-1 register, then the output register. The
// memory is not cleared after reset; a flag that sets once the first buffer is
// full makes unwritten entries read as zero, so the block is ready right out of reset.
module triple_buffer_dc_tracker_core #(
    parameter int BUFFER_SAMPLES = 256,
    parameter int BUFFER_COUNT   = 3,
    parameter int SAMPLE_BITS    = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [23:0] raw_sample
    input  logic [tbdc_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [31:0] window_sum, [33:32] done_buffer_index, [39:34] zero
    output logic [tbdc_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // buffer_done
    output logic                             o_m_axis_tlast
);
    import tbdc_pkg::*;

    localparam int DEPTH  = BUFFER_SAMPLES * BUFFER_COUNT;
    localparam int POS_W  = $clog2(BUFFER_SAMPLES);
    localparam int BUF_W  = $clog2(BUFFER_COUNT);
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(BUFFER_SAMPLES - 1);
    localparam logic [BUF_W-1:0]  BUF_LAST   = BUF_W'(BUFFER_COUNT - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] RD_ADDR_RST = ADDR_W'((BUFFER_COUNT - 1) * BUFFER_SAMPLES);

    // sample memory
    logic [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd_data;

    // write-side position state
    logic [POS_W-1:0]  r_pos;
    logic [BUF_W-1:0]  r_act;
    logic [BUF_W-1:0]  r_done_buf;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [ADDR_W-1:0] r_rd_addr;
    logic              r_primed;

    // stage 1: read data returns
    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_fresh;
    logic                   r_s1_primed;
    logic                   r_s1_last;
    logic [BUF_W-1:0]       r_s1_idx;

    // output register
    logic                   r_out_valid;
    logic                   r_out_last;
    t_idx                   r_out_idx;
    t_sum                   r_sum;

    logic                   in_acc;
    logic                   out_adv;
    logic                   wrap;
    logic [SAMPLE_BITS-1:0] fresh;
    t_sum                   fresh_ext;
    t_sum                   stale_ext;
    t_sum                   n_sum;
    logic [BUF_W+1:0]       idx_ext;

    assign out_adv         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || out_adv;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign wrap            = (r_pos == POS_LAST);
    assign fresh           = i_s_axis_tdata[SAMPLE_BITS-1:0];

    // Before the first buffer is full the stale entry was never written.
    always_comb begin
        fresh_ext = SUM_W'(signed'(r_s1_fresh));
        stale_ext = r_s1_primed ? SUM_W'(signed'(r_rd_data)) : '0;
        n_sum     = r_sum + fresh_ext - stale_ext;
        idx_ext   = {2'b00, r_s1_idx};
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem[r_wr_addr] <= fresh;
            r_rd_data        <= r_mem[r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_act      <= '0;
            r_done_buf <= '0;
            r_wr_addr  <= '0;
            r_rd_addr  <= RD_ADDR_RST;
            r_primed   <= 1'b0;
        end else if (in_acc) begin
            r_pos     <= wrap ? '0 : r_pos + 1'b1;
            r_wr_addr <= (r_wr_addr == ADDR_LAST) ? '0 : r_wr_addr + 1'b1;
            r_rd_addr <= (r_rd_addr == ADDR_LAST) ? '0 : r_rd_addr + 1'b1;
            if (wrap) begin
                r_done_buf <= r_act;
                r_act      <= (r_act == BUF_LAST) ? '0 : r_act + 1'b1;
                r_primed   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
        if (in_acc) begin
            r_s1_fresh  <= fresh;
            r_s1_primed <= r_primed;
            r_s1_last   <= wrap;
            r_s1_idx    <= wrap ? r_act : r_done_buf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sum       <= '0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_sum <= n_sum;
            end
        end
        if (out_adv && r_s1_valid) begin
            r_out_last <= r_s1_last;
            r_out_idx  <= idx_ext[IDX_W-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {(OUT_DATA_W - WINDOW_W - IDX_W)'(0), r_out_idx,
                              r_sum[WINDOW_W-1:0]};

    // read pointer trails the write pointer by exactly one buffer
    logic [ADDR_W:0] addr_gap;
    always_comb begin
        if (r_wr_addr >= r_rd_addr) begin
            addr_gap = {1'b0, r_wr_addr} - {1'b0, r_rd_addr};
        end else begin
            addr_gap = {1'b0, r_wr_addr} + (ADDR_W+1)'(DEPTH) - {1'b0, r_rd_addr};
        end
    end

    a_addr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        addr_gap == (ADDR_W+1)'(BUFFER_SAMPLES))
        else $error("read pointer lost its one-buffer offset");

    a_primed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_primed |=> r_primed)
        else $error("primed flag dropped");

    a_wrap_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && wrap) |=> (r_pos == '0 && r_primed))
        else $error("buffer wrap did not restart position");

    a_buf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act <= BUF_LAST) && (r_done_buf <= BUF_LAST))
        else $error("buffer index out of range");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_adv) |=> r_s1_valid)
        else $error("stage 1 item lost under stall");

endmodule
